/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They expand to nothing when SYNTH is
// defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication or plain property checked on every rising edge out of reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/aeg_pkg.sv */
// ---------------------------------------------------------------------------
// ADSR envelope generator package
// Widths, codes, payload types and the command and status groups shared by
// the controller and the datapath.
// ---------------------------------------------------------------------------
package aeg_pkg;

  // Number of voices and the width of a voice index.
  localparam int VOICES    = 2;
  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Field and arithmetic widths.
  localparam int LEVEL_W   = 10;
  localparam int MS_W      = 16;
  localparam int COUNT_W   = 32;
  // Time in microseconds fits in MS_W + 10 bits, as 1000 is below 1024.
  localparam int PERIOD_W  = MS_W + 10;
  localparam int DIV_CNT_W = $clog2(PERIOD_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [LEVEL_W-1:0]  FULL_LEVEL = '1;
  localparam logic [PERIOD_W-1:0] US_PER_MS  = PERIOD_W'(1000);

  // Register reset values.
  localparam logic [MS_W-1:0]    ATTACK_RST  = MS_W'(200);
  localparam logic [MS_W-1:0]    DECAY_RST   = MS_W'(200);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(256);
  localparam logic [MS_W-1:0]    RELEASE_RST = MS_W'(1000);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_GATE_ON  = 2'd1,
    OP_GATE_OFF = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_MS     = 2'd0,
    CFG_DECAY_MS      = 2'd1,
    CFG_SUSTAIN_LEVEL = 2'd2,
    CFG_RELEASE_MS    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_ATTACK  = 2'd0,
    SEL_DECAY   = 2'd1,
    SEL_RELEASE = 2'd2
  } period_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_INC,
    ST_UPD,
    ST_GATE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] op;
    logic       voice;
  } in_t;

  typedef struct packed {
    logic               voice_index;
    logic [LEVEL_W-1:0] level;
    logic [2:0]         phase;
    logic               last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              dirty_clr;
    logic              div_start;
    period_sel_e       div_sel;
    logic              period_load;
    logic              inc_load;
    logic              upd_en;
    logic              gate_en;
    logic              gate_attack;
    logic [VIDX_W-1:0] vidx;
    logic              last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
    logic cfg_dirty;
  } sts_t;

endpackage

/* rtl/aeg_divider.sv */
// ---------------------------------------------------------------------------
// Serial period divider
// Restoring division, one quotient bit per cycle. A zero divisor gives a
// zero quotient.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aeg_divider
  import aeg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PERIOD_W-1:0] dividend_i,
  input  logic [LEVEL_W-1:0]  divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [PERIOD_W-1:0] quotient_o
);

  logic [LEVEL_W-1:0]   rem_q;
  logic [PERIOD_W-1:0]  quo_q;
  logic [LEVEL_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [LEVEL_W:0]     shifted;
  logic [LEVEL_W+1:0]   trial;
  logic                 take;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[PERIOD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    take    = ~trial[LEVEL_W+1];
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(PERIOD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? trial[LEVEL_W-1:0] : shifted[LEVEL_W-1:0];
      quo_q <= {quo_q[PERIOD_W-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = (dvs_q == '0) ? '0 : quo_q;

  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q,
                "divider started while a division is running")
  `ASSERT_AT(a_done_ends_busy, clk_i, rst_ni, done_q |-> !busy_q,
             "divider reports done while still busy")

endmodule

/* rtl/aeg_datapath.sv */
// ---------------------------------------------------------------------------
// ADSR envelope datapath
// Configuration registers, step periods, per-voice state, the voice update
// logic and the output register.
// ---------------------------------------------------------------------------
module aeg_datapath
  import aeg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_t                 out_data_o
);

  logic [MS_W-1:0]     attack_q;
  logic [MS_W-1:0]     decay_q;
  logic [LEVEL_W-1:0]  sustain_q;
  logic [MS_W-1:0]     release_q;
  logic                dirty_q;

  logic [PERIOD_W-1:0] per_att_q;
  logic [PERIOD_W-1:0] per_dec_q;
  logic [PERIOD_W-1:0] per_rel_q;

  logic [LEVEL_W-1:0]  vlevel_q [VOICES];
  phase_e              vphase_q [VOICES];
  logic [COUNT_W-1:0]  vcount_q [VOICES];

  phase_e              snap_ph_q;
  logic [LEVEL_W-1:0]  snap_lv_q;
  logic [COUNT_W-1:0]  inc_q;

  out_t                out_q;
  logic                out_valid_q;
  logic                out_free;

  logic [MS_W-1:0]     div_ms;
  logic [LEVEL_W-1:0]  div_span;
  logic [PERIOD_W-1:0] div_dividend;
  logic                div_busy;
  logic                div_done;
  logic [PERIOD_W-1:0] div_quot;

  logic [COUNT_W-1:0]  cnt_cur;
  logic [COUNT_W-1:0]  cnt_sat;
  logic [PERIOD_W-1:0] per_sel;
  logic [COUNT_W:0]    diff;
  logic                reached;
  logic [LEVEL_W-1:0]  lv_step;

  logic                wr_en;
  logic [LEVEL_W-1:0]  wr_lv;
  phase_e              wr_ph;
  logic [COUNT_W-1:0]  wr_cnt;

  // Configuration writes; any write asks for the periods to be worked out again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      decay_q   <= DECAY_RST;
      sustain_q <= SUSTAIN_RST;
      release_q <= RELEASE_RST;
      dirty_q   <= 1'b1;
    end else begin
      dirty_q <= cfg_we_i | (dirty_q & ~cmd_i.dirty_clr);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ATTACK_MS:     attack_q  <= cfg_data_i[MS_W-1:0];
          CFG_DECAY_MS:      decay_q   <= cfg_data_i[MS_W-1:0];
          CFG_SUSTAIN_LEVEL: sustain_q <= cfg_data_i[LEVEL_W-1:0];
          CFG_RELEASE_MS:    release_q <= cfg_data_i[MS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Divider operands: phase time in microseconds over the phase's level span.
  always_comb begin
    case (cmd_i.div_sel)
      SEL_ATTACK: begin
        div_ms   = attack_q;
        div_span = FULL_LEVEL;
      end
      SEL_DECAY: begin
        div_ms   = decay_q;
        div_span = FULL_LEVEL - sustain_q;
      end
      SEL_RELEASE: begin
        div_ms   = release_q;
        div_span = sustain_q;
      end
      default: begin
        div_ms   = '0;
        div_span = '0;
      end
    endcase
    div_dividend = PERIOD_W'(div_ms) * US_PER_MS;
  end

  aeg_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_span),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Step period registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.period_load) begin
      case (cmd_i.div_sel)
        SEL_ATTACK:  per_att_q <= div_quot;
        SEL_DECAY:   per_dec_q <= div_quot;
        SEL_RELEASE: per_rel_q <= div_quot;
        default: ;
      endcase
    end
  end

  // First half of a voice step: take a copy of the voice and bump its counter.
  always_comb begin
    cnt_cur = vcount_q[cmd_i.vidx];
    cnt_sat = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.inc_load) begin
      snap_ph_q <= vphase_q[cmd_i.vidx];
      snap_lv_q <= vlevel_q[cmd_i.vidx];
      inc_q     <= cnt_sat;
    end
  end

  // Second half of a voice step, or a gate, gives the new voice state.
  always_comb begin
    case (snap_ph_q)
      PH_ATTACK:  per_sel = per_att_q;
      PH_DECAY:   per_sel = per_dec_q;
      PH_RELEASE: per_sel = per_rel_q;
      default:    per_sel = '0;
    endcase
    diff    = {1'b0, inc_q} - (COUNT_W + 1)'(per_sel);
    reached = ~diff[COUNT_W];
    lv_step = snap_lv_q;

    wr_lv  = snap_lv_q;
    wr_ph  = snap_ph_q;
    wr_cnt = vcount_q[cmd_i.vidx];

    if (cmd_i.gate_en) begin
      wr_lv = vlevel_q[cmd_i.vidx];
      if (cmd_i.gate_attack) begin
        wr_ph  = PH_ATTACK;
        wr_cnt = COUNT_W'(per_att_q);
      end else begin
        wr_ph  = PH_RELEASE;
        wr_cnt = COUNT_W'(per_rel_q);
      end
    end else begin
      case (snap_ph_q)
        PH_SUSTAIN: begin
          wr_lv = sustain_q;
        end
        PH_ATTACK: begin
          wr_cnt = inc_q;
          if (reached) begin
            wr_cnt = diff[COUNT_W-1:0];
            lv_step = (snap_lv_q != FULL_LEVEL) ? snap_lv_q + LEVEL_W'(1) : snap_lv_q;
            wr_lv   = lv_step;
            if (lv_step == FULL_LEVEL) begin
              wr_ph  = PH_DECAY;
              wr_cnt = COUNT_W'(per_dec_q);
            end
          end
        end
        PH_DECAY: begin
          wr_cnt = inc_q;
          if (reached) begin
            wr_cnt = diff[COUNT_W-1:0];
            lv_step = (snap_lv_q > sustain_q) ? snap_lv_q - LEVEL_W'(1) : snap_lv_q;
            wr_lv   = lv_step;
            if (lv_step <= sustain_q) begin
              wr_lv = sustain_q;
              wr_ph = PH_SUSTAIN;
            end
          end
        end
        PH_RELEASE: begin
          wr_cnt = inc_q;
          if (reached) begin
            wr_cnt = diff[COUNT_W-1:0];
            lv_step = (snap_lv_q != '0) ? snap_lv_q - LEVEL_W'(1) : snap_lv_q;
            wr_lv   = lv_step;
            if (lv_step == '0) begin
              wr_ph  = PH_IDLE;
              wr_cnt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign wr_en    = out_free & (cmd_i.upd_en | cmd_i.gate_en);

  // Voice state, written together with the result that reports it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        vlevel_q[v] <= '0;
        vphase_q[v] <= PH_IDLE;
        vcount_q[v] <= '0;
      end
    end else if (wr_en) begin
      vlevel_q[cmd_i.vidx] <= wr_lv;
      vphase_q[cmd_i.vidx] <= wr_ph;
      vcount_q[cmd_i.vidx] <= wr_cnt;
    end
  end

  // Output register: a result leaves when the receiver does not stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_q.voice_index <= cmd_i.vidx[0];
      out_q.level       <= wr_lv;
      out_q.phase       <= wr_ph;
      out_q.last        <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.div_done  = div_done & ~div_busy;
  assign sts_o.out_free  = out_free;
  assign sts_o.cfg_dirty = dirty_q;

endmodule

/* rtl/aeg_ctrl.sv */
// ---------------------------------------------------------------------------
// ADSR envelope controller
// Sequences period recomputation, the voice steps of a tick (an increment
// and an update state per voice) and the single update of a gate.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aeg_ctrl
  import aeg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e       state_q, state_d;
  period_sel_e       sel_q, sel_d;
  logic [VIDX_W-1:0] vcnt_q, vcnt_d;
  logic              attack_q, attack_d;
  logic              in_take;
  logic              last_voice;
  logic              voice_ok;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sel_q    <= SEL_ATTACK;
      vcnt_q   <= '0;
      attack_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      vcnt_q   <= vcnt_d;
      attack_q <= attack_d;
    end
  end

  assign in_stall_o = ~((state_q == ST_IDLE) & ~sts_i.cfg_dirty);
  assign in_take    = in_valid_i & ~in_stall_o;
  assign last_voice = (vcnt_q == VIDX_W'(VOICES - 1));
  assign voice_ok   = (32'(in_data_i.voice) < 32'(VOICES));

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    vcnt_d   = vcnt_q;
    attack_d = attack_q;
    cmd_o    = '0;
    cmd_o.div_sel     = sel_q;
    cmd_o.vidx        = vcnt_q;
    cmd_o.gate_attack = attack_q;

    case (state_q)
      ST_IDLE: begin
        if (sts_i.cfg_dirty) begin
          cmd_o.dirty_clr = 1'b1;
          sel_d   = SEL_ATTACK;
          state_d = ST_DIV_START;
        end else if (in_take) begin
          if (in_data_i.op == OP_TICK) begin
            vcnt_d  = '0;
            state_d = ST_INC;
          end else if ((in_data_i.op == OP_GATE_ON || in_data_i.op == OP_GATE_OFF)
                       && voice_ok) begin
            vcnt_d   = VIDX_W'(in_data_i.voice);
            attack_d = (in_data_i.op == OP_GATE_ON);
            state_d  = ST_GATE;
          end
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.period_load = 1'b1;
          case (sel_q)
            SEL_ATTACK: begin
              sel_d   = SEL_DECAY;
              state_d = ST_DIV_START;
            end
            SEL_DECAY: begin
              sel_d   = SEL_RELEASE;
              state_d = ST_DIV_START;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_INC: begin
        cmd_o.inc_load = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd_en = 1'b1;
        cmd_o.last   = last_voice;
        if (sts_i.out_free) begin
          if (last_voice) begin
            state_d = ST_IDLE;
          end else begin
            vcnt_d  = vcnt_q + VIDX_W'(1);
            state_d = ST_INC;
          end
        end
      end
      ST_GATE: begin
        cmd_o.gate_en = 1'b1;
        cmd_o.last    = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_AT(a_no_item_while_dirty, clk_i, rst_ni, in_take |-> !sts_i.cfg_dirty,
             "item accepted while step periods are stale")
  `ASSERT_AT(a_tick_ends_idle, clk_i, rst_ni,
             (state_q == ST_UPD && last_voice && sts_i.out_free) |=> state_q == ST_IDLE,
             "tick did not finish after its last voice")

endmodule

/* rtl/adsr_envelope_generator_unit.sv */
// ---------------------------------------------------------------------------
// ADSR envelope generator
// Linear per-voice attack, decay, sustain and release envelope with a
// 10-bit level, driven by microsecond ticks and per-voice gates.
// ---------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i, in_stall_o, in_data_i) carries a tick, a gate
//   on or a gate off. A transfer completes when valid is high and stall low.
// - Output channel (out_valid_o, out_stall_i, out_data_o) carries one result
//   per voice for a tick, in voice order, and one result for a gate; the last
//   result of an item has its last flag set.
// - Configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes the four timing and sustain registers; it is always ready.
// - One item is handled at a time. A gate result is written to the output
//   register in the gate state, after which the block returns to idle and
//   takes the next item; a tick runs an increment state and an update state
//   for each voice in turn.
// - After reset and after every configuration write the three step periods
//   are recomputed by a serial divider, one quotient bit per cycle, and
//   in_stall_o stays high until the recomputation is done.
// - A stalled receiver holds the current result in the output register; the
//   block then waits before writing the next result.
// ---------------------------------------------------------------------------
module adsr_envelope_generator_unit
  import aeg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  aeg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Registers, voice state and result path.
  aeg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/adsr_envelope_generator_unit_tb.sv */
// ---------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives ticks and per-voice gates into the envelope unit and checks every
// reported level, phase and voice against a cycle-free envelope predictor.
// Register settings change between runs of commands, covering the zero
// divisor cases, the longest times and a full climb to the top level.
// ---------------------------------------------------------------------------
module adsr_envelope_generator_unit_tb;
  import aeg_pkg::*;

  // Command code that the unit ignores.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Cycles allowed for an ignored command to clear before a register write.
  localparam int SETTLE_CYCLES = 24;
  localparam int LIMIT_CYCLES  = 600000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;

  // Commands waiting to be driven and envelope reports waiting to arrive.
  in_t  cmd_queue[$];
  out_t envelope_reports[$];

  int unsigned cmds_taken      = 0;
  int unsigned cmds_ignored    = 0;
  int unsigned reports_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  logic [7:0]  phases_seen     = '0;

  // Predictor state: register copies and per-voice envelope.
  logic [MS_W-1:0]    attack_ms_q  = ATTACK_RST;
  logic [MS_W-1:0]    decay_ms_q   = DECAY_RST;
  logic [LEVEL_W-1:0] sustain_q    = SUSTAIN_RST;
  logic [MS_W-1:0]    release_ms_q = RELEASE_RST;
  logic [LEVEL_W-1:0] voice_lvl[VOICES];
  phase_e             voice_ph[VOICES];
  logic [31:0]        voice_cnt[VOICES];

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      voice_lvl[v] = '0;
      voice_ph[v]  = PH_IDLE;
      voice_cnt[v] = '0;
    end
  end

  adsr_envelope_generator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor
  // ---------------------------------------------------------------------------

  // Microseconds per level step for a phase; a zero span gives period zero.
  function automatic logic [31:0] step_period(phase_e ph);
    logic [31:0] ms;
    logic [31:0] span;
    case (ph)
      PH_ATTACK: begin
        ms   = 32'(attack_ms_q);
        span = 32'(FULL_LEVEL);
      end
      PH_DECAY: begin
        ms   = 32'(decay_ms_q);
        span = 32'(FULL_LEVEL) - 32'(sustain_q);
      end
      PH_RELEASE: begin
        ms   = 32'(release_ms_q);
        span = 32'(sustain_q);
      end
      default: return '0;
    endcase
    if (span == 0) return '0;
    return (ms * 32'(US_PER_MS)) / span;
  endfunction

  // Entering a timed phase preloads the counter so the first step is due at once.
  function automatic void enter_phase(int v, phase_e ph);
    voice_ph[v]  = ph;
    voice_cnt[v] = step_period(ph);
  endfunction

  // One microsecond of progress for one voice.
  function automatic void step_voice(int v);
    logic [31:0] per;
    if (voice_ph[v] == PH_SUSTAIN) begin
      voice_lvl[v] = sustain_q;
      return;
    end
    if (voice_ph[v] != PH_ATTACK && voice_ph[v] != PH_DECAY && voice_ph[v] != PH_RELEASE)
      return;
    per = step_period(voice_ph[v]);
    if (voice_cnt[v] != '1) voice_cnt[v] = voice_cnt[v] + 1;
    if (voice_cnt[v] < per) return;
    voice_cnt[v] = voice_cnt[v] - per;
    case (voice_ph[v])
      PH_ATTACK: begin
        if (voice_lvl[v] < FULL_LEVEL) voice_lvl[v] = voice_lvl[v] + 1'b1;
        if (voice_lvl[v] >= FULL_LEVEL) begin
          voice_lvl[v] = FULL_LEVEL;
          enter_phase(v, PH_DECAY);
        end
      end
      PH_DECAY: begin
        if (voice_lvl[v] > sustain_q) voice_lvl[v] = voice_lvl[v] - 1'b1;
        if (voice_lvl[v] <= sustain_q) begin
          voice_lvl[v] = sustain_q;
          voice_ph[v]  = PH_SUSTAIN;
        end
      end
      default: begin
        if (voice_lvl[v] > 0) voice_lvl[v] = voice_lvl[v] - 1'b1;
        if (voice_lvl[v] == 0) begin
          voice_ph[v]  = PH_IDLE;
          voice_cnt[v] = '0;
        end
      end
    endcase
  endfunction

  function automatic out_t voice_report(int v, logic is_last);
    out_t rep;
    rep.voice_index = v[0];
    rep.level       = voice_lvl[v];
    rep.phase       = voice_ph[v];
    rep.last        = is_last;
    return rep;
  endfunction

  // Applies one command and queues the reports that it should produce.
  function automatic void predict_envelopes(in_t cmd);
    int v;
    if (cmd.op == OP_TICK) begin
      for (v = 0; v < VOICES; v++) begin
        step_voice(v);
        envelope_reports.push_back(voice_report(v, v == VOICES - 1));
      end
    end else if ((cmd.op == OP_GATE_ON || cmd.op == OP_GATE_OFF) && int'(cmd.voice) < VOICES) begin
      v = int'(cmd.voice);
      enter_phase(v, cmd.op == OP_GATE_ON ? PH_ATTACK : PH_RELEASE);
      envelope_reports.push_back(voice_report(v, 1'b1));
    end else begin
      cmds_ignored++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic check_report(out_t got);
    out_t want;
    if (envelope_reports.size() == 0) begin
      flag_mismatch($sformatf("unexpected result voice %0d level %0d phase %0d last %0d",
                              got.voice_index, got.level, got.phase, got.last));
      return;
    end
    want = envelope_reports.pop_front();
    reports_checked++;
    phases_seen[got.phase] = 1'b1;
    if (got.voice_index !== want.voice_index)
      flag_mismatch($sformatf("result %0d voice %0d, expected %0d",
                              reports_checked, got.voice_index, want.voice_index));
    if (got.level !== want.level)
      flag_mismatch($sformatf("result %0d level %0d, expected %0d",
                              reports_checked, got.level, want.level));
    if (got.phase !== want.phase)
      flag_mismatch($sformatf("result %0d phase %0d, expected %0d",
                              reports_checked, got.phase, want.phase));
    if (got.last !== want.last)
      flag_mismatch($sformatf("result %0d last %0d, expected %0d",
                              reports_checked, got.last, want.last));
  endtask

  // Every accepted command updates the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      cmds_taken++;
      predict_envelopes(in_data_i);
    end
  end

  // Register writes update the predictor copies.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      reg_writes++;
      case (cfg_index_i)
        CFG_ATTACK_MS:     attack_ms_q  = cfg_data_i[MS_W-1:0];
        CFG_DECAY_MS:      decay_ms_q   = cfg_data_i[MS_W-1:0];
        CFG_SUSTAIN_LEVEL: sustain_q    = cfg_data_i[LEVEL_W-1:0];
        CFG_RELEASE_MS:    release_ms_q = cfg_data_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver: presents queued commands with a random gap after each.
  // ---------------------------------------------------------------------------
  int unsigned in_gap   = 0;
  logic        in_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
      in_burst   <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (cmd_queue.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= cmd_queue.pop_front();
        if ($urandom_range(0, 39) == 0) in_burst <= !in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each transfer, then stalls for a random count.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic        out_burst  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      out_burst   <= 1'b0;
    end else if (out_stall_i) begin
      if (stall_left == 0) out_stall_i <= 1'b0;
      else stall_left <= stall_left - 1;
    end else if (out_valid_o) begin
      check_report(out_data_o);
      if ($urandom_range(0, 39) == 0) out_burst <= !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= hold - 1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, envelope_reports.size());
      $display("adsr_envelope_generator_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic in_t make_cmd(logic [1:0] op, logic voice);
    in_t cmd;
    cmd.op    = op;
    cmd.voice = voice;
    return cmd;
  endfunction

  // Random command with the given percentages of ticks, gate ons and gate offs;
  // the remainder use the reserved code.
  function automatic in_t random_cmd(int unsigned tick_pct, int unsigned on_pct,
                                     int unsigned off_pct);
    int unsigned roll;
    logic        voice;
    roll  = $urandom_range(0, 99);
    voice = 1'($urandom_range(0, 1));
    if (roll < tick_pct) return make_cmd(OP_TICK, voice);
    if (roll < tick_pct + on_pct) return make_cmd(OP_GATE_ON, voice);
    if (roll < tick_pct + on_pct + off_pct) return make_cmd(OP_GATE_OFF, voice);
    return make_cmd(OP_RESERVED, voice);
  endfunction

  // Times are mostly short so that envelopes move within a few ticks.
  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 3))
      0:       return MS_W'($urandom_range(0, 2));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return MS_W'($urandom);
      default: return MS_W'($urandom_range(0, 8));
    endcase
  endfunction

  // Waits until every command is taken and every report is in, then lets an
  // ignored command clear. Returns on a rising edge.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_valid_i || envelope_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back writes of all four registers; starts on a rising edge.
  task automatic configure(logic [MS_W-1:0] atk, logic [MS_W-1:0] dcy,
                           logic [LEVEL_W-1:0] sus, logic [MS_W-1:0] rel);
    cfg_reg_e            idx[4];
    logic [CFG_DAT_W-1:0] val[4];
    idx = '{CFG_ATTACK_MS, CFG_DECAY_MS, CFG_SUSTAIN_LEVEL, CFG_RELEASE_MS};
    val = '{atk, dcy, CFG_DAT_W'(sus), rel};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i);
      while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [LEVEL_W-1:0] sus;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed run at reset settings: gates from idle, a release that ends at
    // once at zero, and the reserved code on both voices.
    @(negedge clk_i);
    cmd_queue.push_back(make_cmd(OP_TICK, 1'b0));
    cmd_queue.push_back(make_cmd(OP_GATE_OFF, 1'b0));
    cmd_queue.push_back(make_cmd(OP_TICK, 1'b1));
    cmd_queue.push_back(make_cmd(OP_GATE_ON, 1'b0));
    cmd_queue.push_back(make_cmd(OP_GATE_ON, 1'b1));
    cmd_queue.push_back(make_cmd(OP_TICK, 1'b0));
    cmd_queue.push_back(make_cmd(OP_TICK, 1'b1));
    cmd_queue.push_back(make_cmd(OP_RESERVED, 1'b0));
    cmd_queue.push_back(make_cmd(OP_RESERVED, 1'b1));
    cmd_queue.push_back(make_cmd(OP_GATE_OFF, 1'b1));
    cmd_queue.push_back(make_cmd(OP_TICK, 1'b0));
    wait_drained();

    // Zero attack time and zero sustain, so release steps on every tick.
    configure('0, '1, '0, '1);
    @(negedge clk_i);
    cmd_queue.push_back(make_cmd(OP_GATE_ON, 1'b0));
    repeat (3) cmd_queue.push_back(make_cmd(OP_TICK, 1'b0));
    cmd_queue.push_back(make_cmd(OP_GATE_OFF, 1'b0));
    repeat (5) cmd_queue.push_back(make_cmd(OP_TICK, 1'b1));
    wait_drained();

    // Full climb: both voices attack at one step per tick to the top level,
    // decay to a high sustain and settle there. Gate offs are left out.
    sus = LEVEL_W'($urandom_range(980, 1010));
    configure(MS_W'($urandom_range(0, 1)), '0, sus, MS_W'($urandom_range(0, 2)));
    @(negedge clk_i);
    cmd_queue.push_back(make_cmd(OP_GATE_ON, 1'b0));
    cmd_queue.push_back(make_cmd(OP_GATE_ON, 1'b1));
    repeat (1120) cmd_queue.push_back(random_cmd(97, 2, 0));
    wait_drained();

    // Busy runs with frequent gates under varied settings, starting from the
    // high levels left by the climb.
    for (int run = 0; run < 5; run++) begin
      case (run)
        0: configure(pick_ms(), '0, '1, pick_ms());            // decay span of zero
        2: configure('0, pick_ms(), '0, '0);                   // release span of zero
        3: configure('1, '1, LEVEL_W'($urandom_range(0, 1023)), '1);
        default: configure(pick_ms(), pick_ms(), LEVEL_W'($urandom_range(0, 1023)), pick_ms());
      endcase
      @(negedge clk_i);
      repeat (50) cmd_queue.push_back(random_cmd(74, 12, 10));
      wait_drained();
    end

    $display("Ran %0d commands (%0d ignored) and checked %0d envelope reports.",
             cmds_taken, cmds_ignored, reports_checked);
    $display("Made %0d register writes; phases reported (bit per phase): %05b.",
             reg_writes, phases_seen[4:0]);
    if (mismatches == 0) begin
      $display("adsr_envelope_generator_unit regression: pass");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("adsr_envelope_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
